@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is low
`define FBTP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbtp check failed");

// condition that must never be seen
`define FBTP_NEVER(lbl, clk, rst_n, expr) \
    `FBTP_ASSERT(lbl, clk, rst_n, !(expr))

`endif

@@ hdl/fbtp_pkg.sv @@
package fbtp_pkg;

    localparam int unsigned QUO_W = 8;
    localparam int unsigned LANES = 3;

    localparam logic [12:0] RESET_WIDTH  = 13'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;
    localparam logic [14:0] RESET_PITCH  = 15'd640;
    localparam logic [1:0]  RESET_MODE   = 2'd0;

    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_RGB565  = 2'd1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    localparam logic [15:0] CHECK_YELLOW = 16'hFFE0;

    typedef enum logic [2:0] {
        KIND_DIRECT,
        KIND_IDX_BAR,
        KIND_GREY,
        KIND_TILE,
        KIND_RGB_BAR,
        KIND_GRADIENT
    } kind_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [25:0] byte_offset;
        logic        inside_frame;
    } result_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [14:0] line_pitch;
        logic [1:0]  depth_mode;
    } cfg_t;

    typedef struct packed {
        logic [12:0] per;
        logic [12:0] w_m1;
        logic [12:0] w_m1_nz;
        logic [12:0] sec;
        logic [13:0] sec2;
        logic [12:0] grid_h;
        logic [12:0] h_m1_nz;
        logic        w_gt1;
        logic        pitch_ok16;
    } cfgd_t;

    typedef struct packed {
        logic [20:0] rem;
        logic [20:0] dsr;
        logic [7:0]  quo;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        kind_t             kind;
        logic [15:0]       direct;
        logic [25:0]       offset;
        logic              in_frame;
    } stage_t;

    function automatic logic [15:0] bar_color(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'hF800;
            4'd2:    c = 16'h07E0;
            4'd3:    c = 16'h001F;
            4'd4:    c = 16'hFFE0;
            4'd5:    c = 16'h07FF;
            4'd6:    c = 16'hF81F;
            4'd7:    c = 16'hFFFF;
            4'd8:    c = 16'h7BEF;
            4'd9:    c = 16'hFAE0;
            4'd10:   c = 16'h041F;
            4'd11:   c = 16'h8210;
            4'd12:   c = 16'hFA10;
            4'd13:   c = 16'h83F0;
            4'd14:   c = 16'h821F;
            default: c = 16'h781F;
        endcase
        return c;
    endfunction

    function automatic cfgd_t derive(input cfg_t c);
        cfgd_t       d;
        logic [25:0] third;
        logic [12:0] sec;
        // height/3 as multiply by 2731/8192, exact below 8192
        third = 26'(c.frame_height) * 26'd2731;
        sec = third[25:13];
        if (sec == 13'd0)
        begin
            sec = c.frame_height;
        end
        d.per = (c.frame_width[12:4] == 9'd0) ? 13'd1 : {4'd0, c.frame_width[12:4]};
        d.w_m1 = c.frame_width - 13'd1;
        d.w_gt1 = c.frame_width > 13'd1;
        d.w_m1_nz = d.w_gt1 ? d.w_m1 : 13'd1;
        d.sec = sec;
        d.sec2 = {sec, 1'b0};
        d.grid_h = c.frame_height - {sec[11:0], 1'b0};
        d.h_m1_nz = (c.frame_height > 13'd1) ? (c.frame_height - 13'd1) : 13'd1;
        d.pitch_ok16 = (c.line_pitch != 15'd0)
            && (16'(c.line_pitch) >= 16'({c.frame_width, 1'b0}));
        return d;
    endfunction

endpackage

@@ hdl/framebuffer_test_pattern_pixel_unit.sv @@
`include "assert_macros.svh"

// Test-pattern pixel source: each pixel beat (column, line) yields one result beat
// with the pattern value, the byte offset from the frame base and an in-frame flag.
// One pixel beat is taken every clock while pixel_stall is low; each beat goes through
// the row of eight divider cells (one quotient bit each) and the output register before
// its result reaches the result port. A register write on the APB port
// applies to every pixel beat taken from the next clock edge on.
module framebuffer_test_pattern_pixel_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned MAX_PITCH  = 16384
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  fbtp_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output fbtp_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned CELLS = fbtp_pkg::QUO_W;

    fbtp_pkg::cfg_t    cfg_reg;
    fbtp_pkg::cfg_t    cfg_next;
    fbtp_pkg::cfgd_t   cfgd_reg;
    fbtp_pkg::cfgd_t   cfgd_next;
    fbtp_pkg::cfg_t    cfg_rst;
    logic              wr;
    logic [12:0]       sat_w;
    logic [12:0]       sat_h;
    logic [14:0]       sat_p;

    logic [CELLS:0]    vld;
    logic [CELLS:0]    stl;
    fbtp_pkg::stage_t  stg [0:CELLS];

    fbtp_pkg::result_t asm_result;
    logic              out_valid_reg;
    fbtp_pkg::result_t result_reg;
    logic              out_load;

    // register port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    assign cfg_rst = '{frame_width:  fbtp_pkg::RESET_WIDTH,
                       frame_height: fbtp_pkg::RESET_HEIGHT,
                       line_pitch:   fbtp_pkg::RESET_PITCH,
                       depth_mode:   fbtp_pkg::RESET_MODE};

    always_comb
    begin
        sat_w = (32'(pwdata[12:0]) > 32'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : pwdata[12:0];
        sat_h = (32'(pwdata[12:0]) > 32'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : pwdata[12:0];
        sat_p = (32'(pwdata[14:0]) > 32'(MAX_PITCH)) ? 15'(MAX_PITCH) : pwdata[14:0];
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (paddr[3:2])
                fbtp_pkg::REG_WIDTH:  cfg_next.frame_width  = sat_w;
                fbtp_pkg::REG_HEIGHT: cfg_next.frame_height = sat_h;
                fbtp_pkg::REG_PITCH:  cfg_next.line_pitch   = sat_p;
                fbtp_pkg::REG_MODE:   cfg_next.depth_mode   = pwdata[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
        // derived values follow the register in the same edge
        cfgd_next = fbtp_pkg::derive(cfg_next);
    end

    always_comb
    begin
        case (paddr[3:2])
            fbtp_pkg::REG_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            fbtp_pkg::REG_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            fbtp_pkg::REG_PITCH:  prdata = 32'(cfg_reg.line_pitch);
            fbtp_pkg::REG_MODE:   prdata = 32'(cfg_reg.depth_mode);
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= cfg_rst;
            cfgd_reg <= fbtp_pkg::derive(cfg_rst);
        end
        else
        begin
            cfg_reg  <= cfg_next;
            cfgd_reg <= cfgd_next;
        end
    end

    // datapath
    fbtp_entry u_entry (
        .pixel (pixel),
        .cfg   (cfg_reg),
        .cfgd  (cfgd_reg),
        .stage (stg[0])
    );

    assign vld[0]      = pixel_valid;
    assign pixel_stall = stl[0];

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        fbtp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (vld[k]),
            .up_stall (stl[k]),
            .up_data  (stg[k]),
            .dn_valid (vld[k+1]),
            .dn_stall (stl[k+1]),
            .dn_data  (stg[k+1])
        );
    end

    fbtp_assemble u_assemble (
        .stage  (stg[CELLS]),
        .result (asm_result)
    );

    // output register parts the result side from the cell row
    assign stl[CELLS] = out_valid_reg && result_stall;
    assign out_load   = !stl[CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld[CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && vld[CELLS])
        begin
            result_reg <= asm_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `FBTP_ASSERT(a_outside_zero, clk, rst_n, result_valid && !result.inside_frame |-> result.pixel_value == 16'd0 && result.byte_offset == 26'd0)
    `FBTP_NEVER(a_full_takes, clk, rst_n, (&vld[CELLS:1]) && result_valid && result_stall && !pixel_stall)
    `FBTP_ASSERT(a_cell0_empty, clk, rst_n, !vld[1] && !(pixel_valid && !pixel_stall) |=> !vld[1])

endmodule

@@ hdl/fbtp_entry.sv @@
module fbtp_entry (
    input  fbtp_pkg::pixel_t pixel,
    input  fbtp_pkg::cfg_t   cfg,
    input  fbtp_pkg::cfgd_t  cfgd,
    output fbtp_pkg::stage_t stage
);

    logic [12:0] x;
    logic [12:0] y;
    logic        in_frame;
    logic        band0;
    logic        band1;
    logic [14:0] mult_p;
    logic [26:0] prod;
    logic [27:0] sum;
    logic [12:0] y_rel;
    logic [12:0] h_rest;
    logic [7:0]  ramp;
    logic [19:0] n0, n1, n2;
    logic [12:0] d0, d1, d2;

    always_comb
    begin
        x = {1'b0, pixel.pixel_x};
        y = {1'b0, pixel.pixel_y};
        in_frame = (x < cfg.frame_width) && (y < cfg.frame_height);
        band0 = y < cfgd.sec;
        band1 = {1'b0, y} < cfgd.sec2;
        mult_p = (cfg.depth_mode == fbtp_pkg::MODE_RGB565)
            ? {1'b0, cfg.line_pitch[14:1]} : cfg.line_pitch;
        prod = 27'(pixel.pixel_y) * 27'(mult_p);
        sum = {1'b0, prod} + 28'(pixel.pixel_x);
        y_rel = y - cfgd.sec2[12:0];
        h_rest = cfg.frame_height - 13'd1 - y;
        ramp = pixel.pixel_x[7:0] + pixel.pixel_y[7:0];

        n0 = 20'd0;
        n1 = 20'd0;
        n2 = 20'd0;
        d0 = 13'd1;
        d1 = 13'd1;
        d2 = 13'd1;
        stage.kind = fbtp_pkg::KIND_DIRECT;
        stage.direct = 16'd0;

        if (in_frame)
        begin
            case (cfg.depth_mode)
                fbtp_pkg::MODE_RGB565:
                begin
                    if (cfgd.pitch_ok16)
                    begin
                        if (band0)
                        begin
                            stage.kind = fbtp_pkg::KIND_RGB_BAR;
                            n0 = 20'(x);
                            d0 = cfgd.per;
                        end
                        else if (band1)
                        begin
                            stage.kind = fbtp_pkg::KIND_GRADIENT;
                            n0 = 20'({x, 5'b0}) - 20'(x);
                            d0 = cfgd.w_m1_nz;
                            n1 = 20'({h_rest, 6'b0}) - 20'(h_rest);
                            d1 = cfgd.sec;
                            n2 = 20'({y, 5'b0}) - 20'(y);
                            d2 = cfgd.h_m1_nz;
                        end
                        else
                        begin
                            // checker cells 32 wide, 16 high
                            stage.direct = (x[5] ^ y[4]) ? fbtp_pkg::CHECK_YELLOW : 16'd0;
                        end
                    end
                end
                fbtp_pkg::MODE_INDEXED:
                begin
                    if (cfg.line_pitch != 15'd0)
                    begin
                        if (band0)
                        begin
                            stage.kind = fbtp_pkg::KIND_IDX_BAR;
                            n0 = 20'(x);
                            d0 = cfgd.per;
                        end
                        else if (band1)
                        begin
                            if (cfgd.w_gt1)
                            begin
                                stage.kind = fbtp_pkg::KIND_GREY;
                                n0 = 20'({x, 8'b0}) - 20'(x);
                                d0 = cfgd.w_m1;
                            end
                        end
                        else
                        begin
                            stage.kind = fbtp_pkg::KIND_TILE;
                            n0 = 20'({y_rel, 4'b0});
                            d0 = cfgd.grid_h;
                            n1 = 20'({x, 4'b0});
                            d1 = cfg.frame_width;
                        end
                    end
                end
                default:
                begin
                    if (cfg.line_pitch != 15'd0)
                    begin
                        stage.direct = {8'd0, ramp};
                    end
                end
            endcase
        end

        stage.in_frame = in_frame;
        if (!in_frame)
        begin
            stage.offset = 26'd0;
        end
        else if (cfg.depth_mode == fbtp_pkg::MODE_RGB565)
        begin
            stage.offset = {sum[24:0], 1'b0};
        end
        else
        begin
            stage.offset = sum[25:0];
        end

        // divisor aligned to the top quotient bit
        stage.lane[0].rem = 21'(n0);
        stage.lane[0].dsr = 21'({d0, 7'b0});
        stage.lane[0].quo = 8'd0;
        stage.lane[1].rem = 21'(n1);
        stage.lane[1].dsr = 21'({d1, 7'b0});
        stage.lane[1].quo = 8'd0;
        stage.lane[2].rem = 21'(n2);
        stage.lane[2].dsr = 21'({d2, 7'b0});
        stage.lane[2].quo = 8'd0;
    end

endmodule

@@ hdl/fbtp_cell.sv @@
module fbtp_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  fbtp_pkg::stage_t up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output fbtp_pkg::stage_t dn_data
);

    logic             valid_reg;
    fbtp_pkg::stage_t data_reg;
    fbtp_pkg::stage_t data_next;
    logic             load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = !up_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // one restoring quotient bit per lane
    always_comb
    begin
        data_next = up_data;
        for (int i = 0; i < fbtp_pkg::LANES; i++)
        begin
            if (up_data.lane[i].rem >= up_data.lane[i].dsr)
            begin
                data_next.lane[i].rem = up_data.lane[i].rem - up_data.lane[i].dsr;
                data_next.lane[i].quo = {up_data.lane[i].quo[6:0], 1'b1};
            end
            else
            begin
                data_next.lane[i].quo = {up_data.lane[i].quo[6:0], 1'b0};
            end
            data_next.lane[i].dsr = up_data.lane[i].dsr >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/fbtp_assemble.sv @@
module fbtp_assemble (
    input  fbtp_pkg::stage_t  stage,
    output fbtp_pkg::result_t result
);

    logic [7:0] q0, q1, q2;
    logic [3:0] by, bx;

    always_comb
    begin
        q0 = stage.lane[0].quo;
        q1 = stage.lane[1].quo;
        q2 = stage.lane[2].quo;
        by = (q0 > 8'd15) ? 4'hF : q0[3:0];
        bx = (q1 > 8'd15) ? 4'hF : q1[3:0];
        case (stage.kind)
            fbtp_pkg::KIND_DIRECT:   result.pixel_value = stage.direct;
            fbtp_pkg::KIND_IDX_BAR:  result.pixel_value = {12'd0, q0[3:0]};
            fbtp_pkg::KIND_GREY:     result.pixel_value = {8'd0, q0};
            fbtp_pkg::KIND_TILE:     result.pixel_value = {8'd0, by, bx};
            fbtp_pkg::KIND_RGB_BAR:  result.pixel_value = fbtp_pkg::bar_color(q0[3:0]);
            fbtp_pkg::KIND_GRADIENT: result.pixel_value = {q0[4:0], q1[5:0], q2[4:0]};
            default:                 result.pixel_value = 16'd0;
        endcase
        result.byte_offset  = stage.offset;
        result.inside_frame = stage.in_frame;
    end

endmodule

@@ sim/framebuffer_test_pattern_pixel_unit_tb.sv @@
module framebuffer_test_pattern_pixel_unit_tb;

    localparam int unsigned WIDTH_CAP  = 4096;
    localparam int unsigned HEIGHT_CAP = 4096;
    localparam int unsigned PITCH_CAP  = 16384;
    localparam int unsigned PIPE_DEPTH = 9;
    localparam int unsigned STALL_LIMIT = 3000;

    logic              clk;
    logic              rst_n;
    logic              pixel_valid;
    logic              pixel_stall;
    fbtp_pkg::pixel_t  pixel;
    logic              result_valid;
    logic              result_stall;
    fbtp_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // register shadow used for prediction
    int unsigned fb_width;
    int unsigned fb_height;
    int unsigned fb_pitch;
    int unsigned fb_mode;

    fbtp_pkg::result_t pending_pixels[$];
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned results_seen;
    int unsigned reg_writes;
    bit          no_idle;
    bit          long_hold;
    int unsigned quiet_cycles;

    framebuffer_test_pattern_pixel_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [15:0] bar_rgb(input int unsigned idx);
        logic [15:0] c;
        case (idx)
            0:       c = 16'h0000;
            1:       c = 16'hF800;
            2:       c = 16'h07E0;
            3:       c = 16'h001F;
            4:       c = 16'hFFE0;
            5:       c = 16'h07FF;
            6:       c = 16'hF81F;
            7:       c = 16'hFFFF;
            8:       c = 16'h7BEF;
            9:       c = 16'hFAE0;
            10:      c = 16'h041F;
            11:      c = 16'h8210;
            12:      c = 16'hFA10;
            13:      c = 16'h83F0;
            14:      c = 16'h821F;
            default: c = 16'h781F;
        endcase
        return c;
    endfunction

    function automatic int unsigned bar_of(input int unsigned x, input int unsigned w);
        int unsigned per;
        per = w / 16;
        if (per == 0)
        begin
            per = 1;
        end
        return (x / per) & 4'hF;
    endfunction

    function automatic fbtp_pkg::result_t pattern_pixel(input int unsigned x,
                                                        input int unsigned y);
        fbtp_pkg::result_t r;
        int unsigned w;
        int unsigned h;
        int unsigned p;
        int unsigned sec;
        int unsigned v;
        int unsigned gh;
        int unsigned bx;
        int unsigned by;
        int unsigned cr;
        int unsigned cg;
        int unsigned cb;
        w = fb_width;
        h = fb_height;
        p = fb_pitch;
        v = 0;
        r = '0;
        if (x < w && y < h)
        begin
            sec = h / 3;
            if (sec == 0)
            begin
                sec = h;
            end
            r.inside_frame = 1'b1;
            if (fb_mode == fbtp_pkg::MODE_RGB565)
            begin
                r.byte_offset = 26'((y * (p / 2) + x) * 2);
                if (p != 0 && p >= 2 * w)
                begin
                    if (y < sec)
                    begin
                        v = bar_rgb(bar_of(x, w));
                    end
                    else if (y < 2 * sec)
                    begin
                        cr = (x * 31) / (w > 1 ? w - 1 : 1);
                        cg = (((h - 1 - y) * 63) / sec) & 8'hFF;
                        cb = (y * 31) / (h > 1 ? h - 1 : 1);
                        v = ((cr & 5'h1F) << 11) | ((cg & 6'h3F) << 5) | (cb & 5'h1F);
                    end
                    else
                    begin
                        v = (((x / 32) ^ (y / 16)) & 1) ? fbtp_pkg::CHECK_YELLOW : 0;
                    end
                end
            end
            else
            begin
                r.byte_offset = 26'(y * p + x);
                if (p != 0)
                begin
                    if (fb_mode != fbtp_pkg::MODE_INDEXED)
                    begin
                        v = (x + y) & 8'hFF;
                    end
                    else if (y < sec)
                    begin
                        v = bar_of(x, w);
                    end
                    else if (y < 2 * sec)
                    begin
                        v = w > 1 ? ((x * 255) / (w - 1)) & 8'hFF : 0;
                    end
                    else
                    begin
                        gh = h - 2 * sec;
                        by = ((y - 2 * sec) * 16) / gh;
                        bx = (x * 16) / w;
                        if (by > 15) by = 15;
                        if (bx > 15) bx = 15;
                        v = (by << 4) | bx;
                    end
                end
            end
        end
        r.pixel_value = 16'(v);
        return r;
    endfunction

    // result side: random stall per beat, plus an occasional long hold-off
    initial
    begin
        int unsigned n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            if (long_hold)
            begin
                n = 60;
                long_hold = 1'b0;
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin
        fbtp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat %h", $time, result);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (result.pixel_value !== want.pixel_value)
                begin
                    mismatches++;
                    $display("%0t: pixel_value expected %h got %h", $time,
                             want.pixel_value, result.pixel_value);
                end
                if (result.byte_offset !== want.byte_offset)
                begin
                    mismatches++;
                    $display("%0t: byte_offset expected %h got %h", $time,
                             want.byte_offset, result.byte_offset);
                end
                if (result.inside_frame !== want.inside_frame)
                begin
                    mismatches++;
                    $display("%0t: inside_frame expected %b got %b", $time,
                             want.inside_frame, result.inside_frame);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("framebuffer_test_pattern_pixel_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic send_pixel(input int unsigned x, input int unsigned y);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid   <= 1'b1;
        pixel.pixel_x <= 12'(x);
        pixel.pixel_y <= 12'(y);
        do @(posedge clk); while (pixel_stall);
        pending_pixels.push_back(pattern_pixel(x, y));
        pixels_sent++;
    endtask

    task automatic drain;
        pixel_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            fbtp_pkg::REG_WIDTH:
                fb_width = (value & 13'h1FFF) > WIDTH_CAP ? WIDTH_CAP : value & 13'h1FFF;
            fbtp_pkg::REG_HEIGHT:
                fb_height = (value & 13'h1FFF) > HEIGHT_CAP ? HEIGHT_CAP : value & 13'h1FFF;
            fbtp_pkg::REG_PITCH:
                fb_pitch = (value & 15'h7FFF) > PITCH_CAP ? PITCH_CAP : value & 15'h7FFF;
            default:
                fb_mode = value & 2'h3;
        endcase
        reg_writes++;
        repeat (2) @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned p, input int unsigned m);
        write_reg(fbtp_pkg::REG_WIDTH, w);
        write_reg(fbtp_pkg::REG_HEIGHT, h);
        write_reg(fbtp_pkg::REG_PITCH, p);
        write_reg(fbtp_pkg::REG_MODE, m);
    endtask

    // corners, band edges and just outside the frame
    task automatic send_landmarks;
        send_pixel(0, 0);
        send_pixel(fb_width - 1, 0);
        send_pixel(fb_width > 0 ? fb_width - 1 : 0, fb_height / 3);
        send_pixel(fb_width / 2, 2 * (fb_height / 3));
        send_pixel(fb_width - 1, fb_height - 1);
        send_pixel(fb_width, 0);
        send_pixel(0, fb_height);
        send_pixel(4095, 4095);
    endtask

    task automatic test_reset_frame;
        send_landmarks();
    endtask

    task automatic test_modes_directed;
        set_frame(640, 480, 1280, fbtp_pkg::MODE_RGB565);
        send_landmarks();
        write_reg(fbtp_pkg::REG_PITCH, 1279);
        send_pixel(10, 10);
        write_reg(fbtp_pkg::REG_MODE, 2);
        send_pixel(200, 100);
        write_reg(fbtp_pkg::REG_PITCH, 0);
        send_pixel(5, 5);
        set_frame(0, 0, 16, 3);
        send_pixel(0, 0);
    endtask

    task automatic test_saturation;
        set_frame(8191, 8191, 32767, fbtp_pkg::MODE_INDEXED);
        send_pixel(4095, 4095);
        send_pixel(4095, 2800);
        set_frame(1, 2, 1, fbtp_pkg::MODE_INDEXED);
        send_pixel(0, 1);
        send_pixel(0, 0);
    endtask

    function automatic int unsigned pick_size;
        case ($urandom_range(0, 7))
            0:       return $urandom_range(1, 3);
            1:       return $urandom_range(15, 17);
            2:       return 4096;
            3:       return 8191;
            default: return $urandom_range(1, 700);
        endcase
    endfunction

    task automatic test_random_frames;
        int unsigned x;
        int unsigned y;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(fbtp_pkg::REG_WIDTH, pick_size());
            write_reg(fbtp_pkg::REG_HEIGHT, pick_size());
            case ($urandom_range(0, 4))
                0:       write_reg(fbtp_pkg::REG_PITCH, 0);
                1:       write_reg(fbtp_pkg::REG_PITCH, $urandom_range(0, 32767));
                2:       write_reg(fbtp_pkg::REG_PITCH, fb_width);
                default: write_reg(fbtp_pkg::REG_PITCH, 2 * fb_width + $urandom_range(0, 64));
            endcase
            write_reg(fbtp_pkg::REG_MODE, $urandom_range(0, 3));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                else
                begin
                    x = $urandom_range(0, fb_width > 0 ? fb_width - 1 : 0);
                    y = $urandom_range(0, fb_height > 0 ? fb_height - 1 : 0);
                end
                send_pixel(x, y);
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure;
        set_frame(4096, 4096, 16384, fbtp_pkg::MODE_RGB565);
        no_idle   = 1'b1;
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        no_idle = 1'b0;
        // sender pauses until every beat is back
        drain();
        for (int i = 0; i < 10; i++)
        begin
            send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        no_idle     = 1'b0;
        long_hold   = 1'b0;
        mismatches  = 0;
        pixels_sent = 0;
        results_seen = 0;
        reg_writes  = 0;
        quiet_cycles = 0;
        fb_width    = fbtp_pkg::RESET_WIDTH;
        fb_height   = fbtp_pkg::RESET_HEIGHT;
        fb_pitch    = fbtp_pkg::RESET_PITCH;
        fb_mode     = fbtp_pkg::RESET_MODE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_modes_directed();
        test_saturation();
        test_random_frames();
        test_backpressure();
        drain();

        $display("%0d pixel beats over %0d register writes, all depth modes and band edges",
                 pixels_sent, reg_writes);
        $display("%0d result beats checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("framebuffer_test_pattern_pixel_unit_tb OK");
        end
        else
        begin
            $display("framebuffer_test_pattern_pixel_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
